// ----- src/lrqh_pkg.sv -----
package lrqh_pkg;

   localparam int STAMP_W  = 32;
   localparam int SENDER_W = 6;
   localparam int AMOUNT_W = 8;
   localparam int CMD_W    = 3;
   localparam int PCNT_W   = 7;

   localparam logic [CMD_W-1:0] CMD_FINISH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DOCK_REQ = 3'd1;
   localparam logic [CMD_W-1:0] CMD_MECH_REQ = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DOCK_ACK = 3'd3;
   localparam logic [CMD_W-1:0] CMD_MECH_ACK = 3'd4;
   localparam logic [CMD_W-1:0] CMD_RELEASE  = 3'd5;

   localparam logic [1:0] EVT_NONE   = 2'd0;
   localparam logic [1:0] EVT_FINISH = 2'd1;
   localparam logic [1:0] EVT_DOCK   = 2'd2;
   localparam logic [1:0] EVT_MECH   = 2'd3;

   localparam logic [PCNT_W-1:0] PCNT_RESET = 7'd2;

   typedef struct packed {
      logic [STAMP_W-1:0]  stamp;
      logic [SENDER_W-1:0] sender;
      logic [AMOUNT_W-1:0] amount;
   } entry_type;

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_INS       = 5'b00010,
      ST_PUT       = 5'b00100,
      ST_REM_START = 5'b01000,
      ST_REM       = 5'b10000
   } state_type;

endpackage

// ----- src/lamport_request_queue_handler_core.sv -----
// finish, ack and other messages: the result is registered and shown in the cycle after the transfer
// requests: one table entry compared and shifted per cycle
// release: dock table then mech table, one entry read and compacted per cycle
// one message at a time: a new message is taken only when idle and no result waits for rsp_ready
// synchronous reset clears clock, fills, ack counters and finish flag; tables need no clear
module lamport_request_queue_handler_core #(
   parameter int TABLE_DEPTH = 64,
   parameter int MAX_PROCS   = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [lrqh_pkg::CMD_W-1:0]             req_command,
   input  logic [lrqh_pkg::SENDER_W-1:0]          req_sender,
   input  logic [lrqh_pkg::STAMP_W-1:0]           req_stamp,
   input  logic [lrqh_pkg::AMOUNT_W-1:0]          req_mech_amount,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_reply_valid,
   output logic [lrqh_pkg::SENDER_W-1:0]          rsp_reply_dest,
   output logic                                   rsp_reply_kind,
   output logic [lrqh_pkg::STAMP_W-1:0]           rsp_reply_stamp,
   output logic [1:0]                             rsp_mode_event,
   output logic [lrqh_pkg::STAMP_W-1:0]           rsp_clock_now,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]       rsp_dock_entries,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]       rsp_mech_entries,
   output logic                                   rsp_overflow,
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [2:0]                             csr_paddr,
   input  logic [31:0]                            csr_pwdata,
   output logic [31:0]                            csr_prdata,
   output logic                                   csr_pready
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int FW = $clog2(TABLE_DEPTH+1);
   localparam int CW = $clog2(MAX_PROCS);
   localparam logic [FW-1:0] DEPTH_F = FW'(TABLE_DEPTH);
   localparam logic [31:0] MAXP_32 = 32'(MAX_PROCS);

   lrqh_pkg::state_type state_ff, state_in;
   lrqh_pkg::entry_type dmem [TABLE_DEPTH];
   lrqh_pkg::entry_type mmem [TABLE_DEPTH];
   lrqh_pkg::entry_type drd_ff, mrd_ff, rd_data, e_ff, e_in, wdata;

   logic [lrqh_pkg::PCNT_W-1:0]  pcnt_ff;
   logic [lrqh_pkg::STAMP_W-1:0] clk_ff, clk_in, m1, m2;
   logic [FW-1:0]                dfill_ff, dfill_in, mfill_ff, mfill_in, wr_ff, wr_in, n_cur;
   logic [CW-1:0]                dack_ff, dack_in, mack_ff, mack_in;
   logic                         fin_ff, fin_in, sel_ff, sel_in;
   logic [AW-1:0]                idx_ff, idx_in, rd_addr, waddr;
   logic                         we;
   logic                         rv_ff, rv_in, rrv_ff, rrv_in, rk_ff, rk_in, ov_ff, ov_in;
   logic [lrqh_pkg::SENDER_W-1:0] rd_ff, rd_in;
   logic [lrqh_pkg::STAMP_W-1:0] rs_ff, rs_in;
   logic [1:0]                   ev_ff, ev_in;
   logic [31:0]                  thr, pc32;
   logic [CW-1:0]                dack_nx, mack_nx;
   logic                         accept, after;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {25'd0, pcnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff <= lrqh_pkg::PCNT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         pcnt_ff <= csr_pwdata[lrqh_pkg::PCNT_W-1:0];
      end
   end

   always_comb begin
      pc32 = {25'd0, pcnt_ff};
      if (pc32 < 32'd2) pc32 = 32'd2;
      if (pc32 > MAXP_32) pc32 = MAXP_32;
      thr = pc32 - 32'd1;
   end

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == lrqh_pkg::ST_IDLE) && !rv_ff;
   assign rd_data   = sel_ff ? mrd_ff : drd_ff;
   assign after     = rd_data > e_ff;
   assign n_cur     = sel_ff ? mfill_ff : dfill_ff;
   assign m1        = ((clk_ff > req_stamp) ? clk_ff : req_stamp) + 32'd1;
   assign m2        = m1 + 32'd1;
   assign dack_nx   = dack_ff + CW'(1);
   assign mack_nx   = mack_ff + CW'(1);

   always_ff @(posedge clock) begin
      if (we && !sel_ff) dmem[waddr] <= wdata;
      if (we && sel_ff) mmem[waddr] <= wdata;
      drd_ff <= dmem[rd_addr];
      mrd_ff <= mmem[rd_addr];
   end

   always_comb begin
      state_in = state_ff;
      clk_in = clk_ff; dfill_in = dfill_ff; mfill_in = mfill_ff;
      dack_in = dack_ff; mack_in = mack_ff; fin_in = fin_ff;
      sel_in = sel_ff; idx_in = idx_ff; wr_in = wr_ff; e_in = e_ff;
      rv_in = rv_ff; rrv_in = rrv_ff; rd_in = rd_ff; rk_in = rk_ff;
      rs_in = rs_ff; ev_in = ev_ff; ov_in = ov_ff;
      rd_addr = idx_ff; waddr = idx_ff; wdata = e_ff; we = 1'b0;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         lrqh_pkg::ST_IDLE: begin
            if (accept) begin
               rrv_in = 1'b0; rd_in = '0; rk_in = 1'b0; rs_in = '0;
               ev_in = lrqh_pkg::EVT_NONE; ov_in = 1'b0;
               e_in = '{stamp: req_stamp, sender: req_sender, amount: '0};
               rv_in = 1'b1;
               if (!fin_ff) begin
                  clk_in = m1;
                  unique case (req_command)
                     lrqh_pkg::CMD_FINISH: begin
                        fin_in = 1'b1;
                        ev_in = lrqh_pkg::EVT_FINISH;
                     end
                     lrqh_pkg::CMD_DOCK_REQ, lrqh_pkg::CMD_MECH_REQ: begin
                        sel_in = (req_command == lrqh_pkg::CMD_MECH_REQ);
                        if (sel_in) e_in.amount = req_mech_amount;
                        clk_in = m2;
                        rrv_in = 1'b1; rd_in = req_sender; rk_in = sel_in; rs_in = m2;
                        if ((sel_in ? mfill_ff : dfill_ff) >= DEPTH_F) begin
                           ov_in = 1'b1;
                        end else begin
                           rv_in = 1'b0;
                           if (sel_in) mfill_in = mfill_ff + FW'(1);
                           else dfill_in = dfill_ff + FW'(1);
                           if ((sel_in ? mfill_ff : dfill_ff) == '0) begin
                              idx_in = '0;
                              state_in = lrqh_pkg::ST_PUT;
                           end else begin
                              idx_in = AW'((sel_in ? mfill_ff : dfill_ff) - FW'(1));
                              rd_addr = idx_in;
                              state_in = lrqh_pkg::ST_INS;
                           end
                        end
                     end
                     lrqh_pkg::CMD_DOCK_ACK: begin
                        dack_in = dack_nx;
                        if ({{(32-CW){1'b0}}, dack_nx} >= thr) begin
                           dack_in = '0;
                           ev_in = lrqh_pkg::EVT_DOCK;
                        end
                     end
                     lrqh_pkg::CMD_MECH_ACK: begin
                        mack_in = mack_nx;
                        if ({{(32-CW){1'b0}}, mack_nx} >= thr) begin
                           mack_in = '0;
                           ev_in = lrqh_pkg::EVT_MECH;
                        end
                     end
                     lrqh_pkg::CMD_RELEASE: begin
                        rv_in = 1'b0;
                        sel_in = 1'b0;
                        state_in = lrqh_pkg::ST_REM_START;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         lrqh_pkg::ST_INS: begin
            we = 1'b1;
            waddr = idx_ff + AW'(1);
            if (after) begin
               wdata = rd_data;
               if (idx_ff == '0) begin
                  state_in = lrqh_pkg::ST_PUT;
               end else begin
                  idx_in = idx_ff - AW'(1);
                  rd_addr = idx_in;
               end
            end else begin
               wdata = e_ff;
               rv_in = 1'b1;
               state_in = lrqh_pkg::ST_IDLE;
            end
         end
         lrqh_pkg::ST_PUT: begin
            we = 1'b1;
            rv_in = 1'b1;
            state_in = lrqh_pkg::ST_IDLE;
         end
         lrqh_pkg::ST_REM_START: begin
            if (n_cur == '0) begin
               if (sel_ff) begin
                  rv_in = 1'b1;
                  state_in = lrqh_pkg::ST_IDLE;
               end else begin
                  sel_in = 1'b1;
               end
            end else begin
               idx_in = '0;
               wr_in = '0;
               rd_addr = '0;
               state_in = lrqh_pkg::ST_REM;
            end
         end
         lrqh_pkg::ST_REM: begin
            wdata = rd_data;
            waddr = wr_ff[AW-1:0];
            if (rd_data.sender != e_ff.sender) begin
               we = 1'b1;
               wr_in = wr_ff + FW'(1);
            end
            if (FW'(idx_ff) + FW'(1) == n_cur) begin
               if (sel_ff) begin
                  mfill_in = wr_in;
                  rv_in = 1'b1;
                  state_in = lrqh_pkg::ST_IDLE;
               end else begin
                  dfill_in = wr_in;
                  sel_in = 1'b1;
                  state_in = lrqh_pkg::ST_REM_START;
               end
            end else begin
               idx_in = idx_ff + AW'(1);
               rd_addr = idx_in;
            end
         end
         default: begin
            state_in = lrqh_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrqh_pkg::ST_IDLE;
         clk_ff <= '0; dfill_ff <= '0; mfill_ff <= '0;
         dack_ff <= '0; mack_ff <= '0; fin_ff <= 1'b0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clk_ff <= clk_in; dfill_ff <= dfill_in; mfill_ff <= mfill_in;
         dack_ff <= dack_in; mack_ff <= mack_in; fin_ff <= fin_in; rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      sel_ff <= sel_in; idx_ff <= idx_in; wr_ff <= wr_in; e_ff <= e_in;
      rrv_ff <= rrv_in; rd_ff <= rd_in; rk_ff <= rk_in; rs_ff <= rs_in;
      ev_ff <= ev_in; ov_ff <= ov_in;
   end

   assign rsp_valid        = rv_ff;
   assign rsp_reply_valid  = rrv_ff;
   assign rsp_reply_dest   = rd_ff;
   assign rsp_reply_kind   = rk_ff;
   assign rsp_reply_stamp  = rs_ff;
   assign rsp_mode_event   = ev_ff;
   assign rsp_clock_now    = clk_ff;
   assign rsp_dock_entries = dfill_ff;
   assign rsp_mech_entries = mfill_ff;
   assign rsp_overflow     = ov_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      dfill_ff <= DEPTH_F && mfill_ff <= DEPTH_F)
      else $error("table fill beyond depth");

   a_busy_no_rsp: assert property (@(posedge clock) disable iff (reset)
      state_ff != lrqh_pkg::ST_IDLE |-> !rv_ff)
      else $error("result shown while table work in progress");

   a_finished_quiet: assert property (@(posedge clock) disable iff (reset)
      accept && fin_ff |=> rv_ff && ev_ff == lrqh_pkg::EVT_NONE && !rrv_ff && $stable(clk_ff))
      else $error("message after finish changed state");

   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      dfill_ff > $past(dfill_ff) |-> dfill_ff == $past(dfill_ff) + FW'(1))
      else $error("dock fill grew by more than one");

endmodule

// ----- sim/tb_lamport_request_queue_handler_core.sv -----
module tb_lamport_request_queue_handler_core;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 64;
   localparam int PROCS = 64;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int SETTLE_CYCLES = 140;
   localparam logic [lrqh_pkg::CMD_W-1:0] CMD_OTHER  = 3'd6;
   localparam logic [lrqh_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
   localparam logic [2:0] CSR_PCOUNT_ADDR = 3'd0;

   typedef struct {
      bit              reply_valid;
      bit [5:0]        reply_dest;
      bit              reply_kind;
      bit [31:0]       reply_stamp;
      bit [1:0]        mode_event;
      bit [31:0]       clock_now;
      bit [6:0]        dock_entries;
      bit [6:0]        mech_entries;
      bit              overflow;
   } reply_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [lrqh_pkg::CMD_W-1:0] req_command = '0;
   logic [lrqh_pkg::SENDER_W-1:0] req_sender = '0;
   logic [lrqh_pkg::STAMP_W-1:0] req_stamp = '0;
   logic [lrqh_pkg::AMOUNT_W-1:0] req_mech_amount = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic rsp_reply_valid;
   logic [lrqh_pkg::SENDER_W-1:0] rsp_reply_dest;
   logic rsp_reply_kind;
   logic [lrqh_pkg::STAMP_W-1:0] rsp_reply_stamp;
   logic [1:0] rsp_mode_event;
   logic [lrqh_pkg::STAMP_W-1:0] rsp_clock_now;
   logic [6:0] rsp_dock_entries;
   logic [6:0] rsp_mech_entries;
   logic rsp_overflow;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   lamport_request_queue_handler_core #(.TABLE_DEPTH(DEPTH), .MAX_PROCS(PROCS)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_command(req_command), .req_sender(req_sender),
      .req_stamp(req_stamp), .req_mech_amount(req_mech_amount),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_reply_valid(rsp_reply_valid), .rsp_reply_dest(rsp_reply_dest),
      .rsp_reply_kind(rsp_reply_kind), .rsp_reply_stamp(rsp_reply_stamp),
      .rsp_mode_event(rsp_mode_event), .rsp_clock_now(rsp_clock_now),
      .rsp_dock_entries(rsp_dock_entries), .rsp_mech_entries(rsp_mech_entries),
      .rsp_overflow(rsp_overflow),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // mirror of the handler state
   bit [6:0]   pcount_reg;
   bit [31:0]  lclock;
   lrqh_pkg::entry_type  dock_q[$];
   lrqh_pkg::entry_type  mech_q[$];
   int         dock_acks;
   int         mech_acks;
   bit         halted;

   reply_type  pending_q[$];
   bit         calm;
   int         errors;
   int         cycles;
   int         sent;
   int         checked;
   int         grants;
   int         overflows;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 30);
   end

   function automatic int ack_goal();
      int p;
      p = int'(pcount_reg);
      if (p < 2) p = 2;
      if (p > PROCS) p = PROCS;
      return p - 1;
   endfunction

   function automatic bit orders_after(lrqh_pkg::entry_type a, lrqh_pkg::entry_type b,
                                       bit with_amount);
      if (a.stamp != b.stamp) return a.stamp > b.stamp;
      if (a.sender != b.sender) return a.sender > b.sender;
      if (with_amount) return a.amount > b.amount;
      return 1'b0;
   endfunction

   function automatic bit sorted_insert(ref lrqh_pkg::entry_type q[$],
                                        input lrqh_pkg::entry_type e,
                                        input bit with_amount);
      int pos;
      if (q.size() >= DEPTH) return 1'b0;
      pos = q.size();
      for (int i = 0; i < q.size(); i++) begin
         if (orders_after(q[i], e, with_amount)) begin
            pos = i;
            break;
         end
      end
      q.insert(pos, e);
      return 1'b1;
   endfunction

   function automatic void drop_sender(ref lrqh_pkg::entry_type q[$], input bit [5:0] s);
      lrqh_pkg::entry_type kept[$];
      foreach (q[i]) if (q[i].sender != s) kept.insert(kept.size(), q[i]);
      q = kept;
   endfunction

   function automatic reply_type handle_message(bit [2:0] cmd, bit [5:0] snd,
                                                bit [31:0] stp, bit [7:0] amt);
      reply_type r;
      lrqh_pkg::entry_type e;
      r = '{default: 0};
      if (!halted) begin
         lclock = ((lclock > stp) ? lclock : stp) + 32'd1;
         e.stamp = stp;
         e.sender = snd;
         e.amount = '0;
         case (cmd)
            lrqh_pkg::CMD_FINISH: begin
               halted = 1'b1;
               r.mode_event = lrqh_pkg::EVT_FINISH;
            end
            lrqh_pkg::CMD_DOCK_REQ, lrqh_pkg::CMD_MECH_REQ: begin
               if (cmd == lrqh_pkg::CMD_DOCK_REQ) begin
                  r.overflow = !sorted_insert(dock_q, e, 1'b0);
               end else begin
                  e.amount = amt;
                  r.overflow = !sorted_insert(mech_q, e, 1'b1);
               end
               lclock = lclock + 32'd1;
               r.reply_valid = 1'b1;
               r.reply_dest = snd;
               r.reply_kind = (cmd == lrqh_pkg::CMD_MECH_REQ);
               r.reply_stamp = lclock;
            end
            lrqh_pkg::CMD_DOCK_ACK: begin
               dock_acks++;
               if (dock_acks >= ack_goal()) begin
                  dock_acks = 0;
                  r.mode_event = lrqh_pkg::EVT_DOCK;
               end
            end
            lrqh_pkg::CMD_MECH_ACK: begin
               mech_acks++;
               if (mech_acks >= ack_goal()) begin
                  mech_acks = 0;
                  r.mode_event = lrqh_pkg::EVT_MECH;
               end
            end
            lrqh_pkg::CMD_RELEASE: begin
               drop_sender(dock_q, snd);
               drop_sender(mech_q, snd);
            end
            default: ;
         endcase
      end
      r.clock_now = lclock;
      r.dock_entries = 7'(dock_q.size());
      r.mech_entries = 7'(mech_q.size());
      return r;
   endfunction

   task automatic report(string what, longint got, longint want);
      errors++;
      $display("mismatch %s at cycle %0d: got %0h expected %0h", what, cycles, got, want);
   endtask

   always @(posedge clock) begin
      reply_type x;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_q.size() == 0) begin
            report("unexpected transfer", 64'd0, 64'd0);
         end else begin
            x = pending_q.pop_front();
            checked++;
            if (x.mode_event == lrqh_pkg::EVT_DOCK || x.mode_event == lrqh_pkg::EVT_MECH)
               grants++;
            if (x.overflow) overflows++;
            if (rsp_reply_valid !== x.reply_valid)
               report("reply_valid", longint'(rsp_reply_valid), longint'(x.reply_valid));
            if (rsp_reply_dest !== x.reply_dest)
               report("reply_dest", longint'(rsp_reply_dest), longint'(x.reply_dest));
            if (rsp_reply_kind !== x.reply_kind)
               report("reply_kind", longint'(rsp_reply_kind), longint'(x.reply_kind));
            if (rsp_reply_stamp !== x.reply_stamp)
               report("reply_stamp", longint'(rsp_reply_stamp), longint'(x.reply_stamp));
            if (rsp_mode_event !== x.mode_event)
               report("mode_event", longint'(rsp_mode_event), longint'(x.mode_event));
            if (rsp_clock_now !== x.clock_now)
               report("clock_now", longint'(rsp_clock_now), longint'(x.clock_now));
            if (rsp_dock_entries !== x.dock_entries)
               report("dock_entries", longint'(rsp_dock_entries), longint'(x.dock_entries));
            if (rsp_mech_entries !== x.mech_entries)
               report("mech_entries", longint'(rsp_mech_entries), longint'(x.mech_entries));
            if (rsp_overflow !== x.overflow)
               report("overflow", longint'(rsp_overflow), longint'(x.overflow));
         end
      end
   end

   // called at a rising edge; returns at the edge of the transfer
   task automatic send_msg(bit [2:0] cmd, bit [5:0] snd, bit [31:0] stp, bit [7:0] amt);
      if (!calm && $urandom_range(99) < 30) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= cmd;
      req_sender <= snd;
      req_stamp <= stp;
      req_mech_amount <= amt;
      do @(posedge clock); while (!req_ready);
      pending_q.insert(pending_q.size(), handle_message(cmd, snd, stp, amt));
      sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic write_pcount(bit [6:0] value);
      wait_drained();
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= CSR_PCOUNT_ADDR;
      csr_pwdata <= {25'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      pcount_reg = value;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic bit [31:0] pick_stamp();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return lclock + $urandom_range(0, 3);
         6: return $urandom;
         7: return 32'd0;
         8: return 32'hFFFF_FFFF;
         default: return lclock - $urandom_range(1, 10);
      endcase
   endfunction

   task automatic test_directed();
      send_msg(lrqh_pkg::CMD_DOCK_REQ, 6'd0, 32'd0, 8'd0);
      send_msg(lrqh_pkg::CMD_DOCK_REQ, 6'd5, 32'd3, 8'd0);
      send_msg(lrqh_pkg::CMD_DOCK_REQ, 6'd5, 32'd3, 8'd0);
      send_msg(lrqh_pkg::CMD_DOCK_REQ, 6'd2, 32'd3, 8'd0);
      send_msg(lrqh_pkg::CMD_MECH_REQ, 6'd5, 32'd4, 8'd255);
      send_msg(lrqh_pkg::CMD_MECH_REQ, 6'd5, 32'd4, 8'd0);
      send_msg(lrqh_pkg::CMD_MECH_REQ, 6'd5, 32'd4, 8'd255);
      send_msg(lrqh_pkg::CMD_MECH_REQ, 6'd63, 32'd1, 8'd170);
      send_msg(lrqh_pkg::CMD_DOCK_ACK, 6'd1, 32'd0, 8'd0);
      send_msg(lrqh_pkg::CMD_MECH_ACK, 6'd1, 32'd0, 8'd0);
      send_msg(CMD_OTHER, 6'd42, 32'd100, 8'd85);
      send_msg(CMD_UNUSED, 6'd21, 32'd7, 8'd0);
      send_msg(lrqh_pkg::CMD_RELEASE, 6'd5, 32'd0, 8'd0);
      send_msg(lrqh_pkg::CMD_RELEASE, 6'd9, 32'd0, 8'd0);
      // clock wrap on the first bump, then on the second
      send_msg(lrqh_pkg::CMD_DOCK_REQ, 6'd63, 32'hFFFF_FFFF, 8'd0);
      send_msg(lrqh_pkg::CMD_MECH_REQ, 6'd0, 32'hFFFF_FFFE, 8'd1);
      send_msg(lrqh_pkg::CMD_RELEASE, 6'd63, 32'hAAAA_5555, 8'd0);
      send_msg(lrqh_pkg::CMD_RELEASE, 6'd0, 32'h5555_AAAA, 8'd0);
      send_msg(lrqh_pkg::CMD_RELEASE, 6'd2, 32'd0, 8'd0);
   endtask

   task automatic test_ack_thresholds();
      bit [6:0] vals[4] = '{7'd0, 7'd1, 7'd127, 7'd64};
      foreach (vals[v]) begin
         write_pcount(vals[v]);
         repeat (ack_goal() + 1) begin
            send_msg(lrqh_pkg::CMD_DOCK_ACK, 6'($urandom_range(63)), pick_stamp(), 8'd0);
            send_msg(lrqh_pkg::CMD_MECH_ACK, 6'($urandom_range(63)), pick_stamp(), 8'd0);
         end
      end
      write_pcount(7'd3);
   endtask

   task automatic test_full_tables();
      repeat (DEPTH + 3) begin
         send_msg(lrqh_pkg::CMD_DOCK_REQ, 6'($urandom_range(0, 3)), $urandom_range(0, 40),
                  8'd0);
         send_msg(lrqh_pkg::CMD_MECH_REQ, 6'($urandom_range(0, 3)), $urandom_range(0, 40),
                  8'($urandom_range(0, 3)));
      end
      for (int s = 0; s < 4; s++) send_msg(lrqh_pkg::CMD_RELEASE, 6'(s), pick_stamp(), 8'd0);
   endtask

   task automatic test_random(int target);
      bit [6:0] settings[6] = '{7'd2, 7'd3, 7'd5, 7'd64, 7'd127, 7'd0};
      int phase_end;
      bit [5:0] s;
      bit [2:0] kind;
      for (int ph = 0; ph < 6; ph++) begin
         write_pcount(ph == 5 ? 7'($urandom_range(0, 127)) : settings[ph]);
         calm = (ph == 2);
         phase_end = sent + target / 6;
         while (sent < phase_end) begin
            if ($urandom_range(99) < 65) begin
               s = 6'($urandom_range(0, 7));
               repeat ($urandom_range(1, 3)) begin
                  kind = $urandom_range(0, 1) ? lrqh_pkg::CMD_MECH_REQ : lrqh_pkg::CMD_DOCK_REQ;
                  send_msg(kind, s, pick_stamp(), 8'($urandom));
               end
               repeat ((ack_goal() > 6) ? $urandom_range(1, 6) : ack_goal()) begin
                  kind = $urandom_range(0, 1) ? lrqh_pkg::CMD_MECH_ACK : lrqh_pkg::CMD_DOCK_ACK;
                  send_msg(kind, 6'($urandom_range(63)), pick_stamp(), 8'($urandom));
               end
               if ($urandom_range(99) < 75)
                  send_msg(lrqh_pkg::CMD_RELEASE, s, pick_stamp(), 8'($urandom));
            end else begin
               send_msg(3'($urandom_range(1, 7)), 6'($urandom_range(63)), $urandom,
                        8'($urandom));
            end
            if (ph == 3 && sent == phase_end - 40) wait_drained();
         end
      end
      calm = 1'b0;
   endtask

   task automatic test_finish();
      wait_drained();
      send_msg(lrqh_pkg::CMD_DOCK_REQ, 6'd7, pick_stamp(), 8'd0);
      send_msg(lrqh_pkg::CMD_FINISH, 6'd1, pick_stamp(), 8'd0);
      send_msg(lrqh_pkg::CMD_FINISH, 6'd2, 32'hFFFF_FFFF, 8'd0);
      for (int c = 1; c < 8; c++)
         send_msg(3'(c), 6'($urandom_range(63)), $urandom, 8'($urandom));
   endtask

   initial begin
      pcount_reg = lrqh_pkg::PCNT_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_ack_thresholds();
      test_full_tables();
      test_random(1520);
      test_finish();
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("%0d messages sent, %0d responses checked", sent, checked);
      $display("%0d grant events, %0d overflowed requests, several process counts",
               grants, overflows);
      if (errors == 0 && pending_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- lamport_request_queue_handler_core.f -----
src/lrqh_pkg.sv
src/lamport_request_queue_handler_core.sv
sim/tb_lamport_request_queue_handler_core.sv
